/* sv/uart_status_and_data_register_model_defines.svh */
// assertion macros shared by the uart status/data register rtl
`ifndef UART_STATUS_AND_DATA_REGISTER_MODEL_DEFINES_SVH
`define UART_STATUS_AND_DATA_REGISTER_MODEL_DEFINES_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define USDR_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("uart_sdr same-cycle check failed");

// next-cycle implication, sampled on clock, off while reset is high
`define USDR_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("uart_sdr next-cycle check failed");

`endif

/* sv/uart_sdr_pkg.sv */
// shared types and constants for the uart status/data register block
package uart_sdr_pkg;

   localparam int RX_QUEUE_DEPTH = 16;
   localparam int RXQ_AW  = (RX_QUEUE_DEPTH > 1) ? $clog2(RX_QUEUE_DEPTH) : 1;
   localparam int RXQ_CW  = $clog2(RX_QUEUE_DEPTH + 1);

   localparam logic [7:0] TC_DELAY_RESET = 8'd20;

   // status image bit positions
   localparam int STAT_TXE  = 7;
   localparam int STAT_TC   = 6;
   localparam int STAT_RXNE = 5;
   localparam int STAT_ORE  = 3;

   typedef enum logic [2:0] {
      OP_TICK        = 3'd0,
      OP_DATA_READ   = 3'd1,
      OP_DATA_WRITE  = 3'd2,
      OP_STATUS_READ = 3'd3,
      OP_PUSH        = 3'd4
   } op_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_frame_end;
      logic       push_dropped;
   } rsp_type;

endpackage

/* sv/uart_sdr_ram.sv */
// generic single-write, single-read ram with registered read
module uart_sdr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/uart_sdr_core.sv */
// receive queue memory, flag state and per-beat sequencing
module uart_sdr_core
   import uart_sdr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  op_type     op,
   input  logic [7:0] data_in,
   input  logic [7:0] tc_delay,
   output rsp_type    rsp
);

`include "uart_status_and_data_register_model_defines.svh"

   localparam logic [RXQ_CW-1:0] DEPTH_C = RXQ_CW'(RX_QUEUE_DEPTH);
   localparam logic [RXQ_CW-1:0] ONE_C   = RXQ_CW'(1);

   logic [RXQ_CW-1:0] rx_count_ff, rx_count_in;
   logic [RXQ_CW-1:0] rx_pos_ff, rx_pos_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] data_reg_ff, data_reg_in;
   logic txe_ff, txe_in, tc_ff, tc_in, rxne_ff, rxne_in, ore_ff, ore_in;
   logic receiving_ff, receiving_in, sending_ff, sending_in;
   logic full_ff, full_in, busy_ff, busy_in, clearpend_ff, clearpend_in;
   logic tc_pend_ff, tc_pend_in;
   logic [7:0] tc_cd_ff, tc_cd_in;

   logic              q_we;
   logic [RXQ_AW-1:0] q_rd_addr;
   logic [7:0]        q_rd_data;
   logic              fwd_hit_ff, fwd_hit_in;
   logic [7:0]        fwd_data_ff;
   logic [7:0]        q_head;

   // ram read runs ahead at the next head position
   assign q_rd_addr  = rx_pos_in[RXQ_AW-1:0];
   assign fwd_hit_in = q_we && (rx_count_ff[RXQ_AW-1:0] == q_rd_addr);
   assign q_head     = fwd_hit_ff ? fwd_data_ff : q_rd_data;

   uart_sdr_ram #(
      .WIDTH (8),
      .DEPTH (RX_QUEUE_DEPTH)
   ) u_rx_queue (
      .clock   (clock),
      .wr_en   (q_we),
      .wr_addr (rx_count_ff[RXQ_AW-1:0]),
      .wr_data (data_in),
      .rd_addr (q_rd_addr),
      .rd_data (q_rd_data)
   );

   always_comb begin
      rx_count_in  = rx_count_ff;
      rx_pos_in    = rx_pos_ff;
      shift_in     = shift_ff;
      data_reg_in  = data_reg_ff;
      txe_in       = txe_ff;
      tc_in        = tc_ff;
      rxne_in      = rxne_ff;
      ore_in       = ore_ff;
      receiving_in = receiving_ff;
      sending_in   = sending_ff;
      full_in      = full_ff;
      busy_in      = busy_ff;
      clearpend_in = clearpend_ff;
      tc_pend_in   = tc_pend_ff;
      tc_cd_in     = tc_cd_ff;
      q_we         = 1'b0;
      rsp          = '0;
      if (accept) begin
         case (op)
            OP_TICK: begin
               // receive half, idle while transmitting
               if (!busy_ff) begin
                  if (receiving_ff) begin
                     receiving_in = 1'b0;
                     if (rx_count_ff == '0) begin
                        receiving_in = 1'b0;
                     end else if (rx_pos_ff >= rx_count_ff || rx_pos_ff >= DEPTH_C) begin
                        rx_count_in = '0;
                        rx_pos_in   = '0;
                     end else begin
                        shift_in = q_head;
                        full_in  = 1'b1;
                     end
                  end else if (full_ff) begin
                     if (rxne_ff) begin
                        ore_in = 1'b1;
                     end else begin
                        data_reg_in  = shift_ff;
                        rxne_in      = 1'b1;
                        full_in      = 1'b0;
                        receiving_in = 1'b1;
                        if (rx_pos_ff < DEPTH_C) begin
                           rx_pos_in = rx_pos_ff + ONE_C;
                        end
                     end
                  end else if (rx_count_ff != '0) begin
                     receiving_in = 1'b1;
                  end
               end
               // transmit half
               if (busy_ff) begin
                  if (tc_pend_ff && tc_cd_ff != 8'd0) begin
                     tc_cd_in = tc_cd_ff - 8'd1;
                  end
                  if (sending_ff) begin
                     rsp.tx_valid = 1'b1;
                     rsp.tx_byte  = shift_ff;
                     full_in      = 1'b0;
                     sending_in   = 1'b0;
                     tc_pend_in   = 1'b1;
                     tc_cd_in     = tc_delay;
                  end else if (full_ff) begin
                     sending_in = 1'b1;
                  end else if (!txe_ff) begin
                     shift_in = data_reg_ff;
                     full_in  = 1'b1;
                     txe_in   = 1'b1;
                  end else if (tc_pend_ff && tc_cd_in == 8'd0) begin
                     busy_in          = 1'b0;
                     tc_pend_in       = 1'b0;
                     tc_in            = 1'b1;
                     rsp.tx_frame_end = 1'b1;
                  end
               end
            end
            OP_DATA_READ: begin
               rsp.read_data = data_reg_ff;
               rxne_in       = 1'b0;
               // rxne was just cleared, so a full shift register always moves
               if (full_ff) begin
                  data_reg_in  = shift_ff;
                  rxne_in      = 1'b1;
                  full_in      = 1'b0;
                  receiving_in = 1'b1;
                  if (rx_pos_ff < DEPTH_C) begin
                     rx_pos_in = rx_pos_ff + ONE_C;
                  end
               end
               if (clearpend_ff) begin
                  clearpend_in = 1'b0;
                  ore_in       = 1'b0;
               end
            end
            OP_DATA_WRITE: begin
               data_reg_in = data_in;
               txe_in      = 1'b0;
               tc_in       = 1'b0;
               busy_in     = 1'b1;
               tc_pend_in  = 1'b0;
               tc_cd_in    = 8'd0;
            end
            OP_STATUS_READ: begin
               rsp.read_data[STAT_TXE]  = txe_ff;
               rsp.read_data[STAT_TC]   = tc_ff;
               rsp.read_data[STAT_RXNE] = rxne_ff;
               rsp.read_data[STAT_ORE]  = ore_ff;
               if (ore_ff) begin
                  clearpend_in = 1'b1;
               end
            end
            OP_PUSH: begin
               if (rx_count_ff >= DEPTH_C) begin
                  rsp.push_dropped = 1'b1;
               end else begin
                  q_we        = 1'b1;
                  rx_count_in = rx_count_ff + ONE_C;
               end
            end
            default: begin
               rsp = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_count_ff  <= '0;
         rx_pos_ff    <= '0;
         shift_ff     <= 8'd0;
         data_reg_ff  <= 8'd0;
         txe_ff       <= 1'b1;
         tc_ff        <= 1'b1;
         rxne_ff      <= 1'b0;
         ore_ff       <= 1'b0;
         receiving_ff <= 1'b0;
         sending_ff   <= 1'b0;
         full_ff      <= 1'b0;
         busy_ff      <= 1'b0;
         clearpend_ff <= 1'b0;
         tc_pend_ff   <= 1'b0;
         tc_cd_ff     <= 8'd0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         rx_count_ff  <= rx_count_in;
         rx_pos_ff    <= rx_pos_in;
         shift_ff     <= shift_in;
         data_reg_ff  <= data_reg_in;
         txe_ff       <= txe_in;
         tc_ff        <= tc_in;
         rxne_ff      <= rxne_in;
         ore_ff       <= ore_in;
         receiving_ff <= receiving_in;
         sending_ff   <= sending_in;
         full_ff      <= full_in;
         busy_ff      <= busy_in;
         clearpend_ff <= clearpend_in;
         tc_pend_ff   <= tc_pend_in;
         tc_cd_ff     <= tc_cd_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= data_in;
   end

   `USDR_ASSERT_NOW(a_count_bounded, 1'b1, rx_count_ff <= DEPTH_C)
   `USDR_ASSERT_NOW(a_tc_means_idle, tc_ff, !busy_ff)
   `USDR_ASSERT_NOW(a_txe_low_means_busy, !txe_ff, busy_ff)

endmodule

/* sv/uart_status_and_data_register_model.sv */
// top level: stream handshake, csr register and response output stage
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  req     | in        | req_tvalid/req_tready | tuser op[2:0], tdata data_in[7:0]
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata read_data, tx_byte; tuser tx_valid,
//          |           |                       | push_dropped; tlast tx_frame_end
//  csr     | in        | csr_valid/csr_ready   | csr_data tc_delay_ticks[7:0]
//
// one beat per cycle unless a held response stalls on rsp_tready: each request is resolved
// in the cycle it is accepted and its response lands in a single output register the next cycle
// the receive queue sits in a ram read ahead at the next head position, with
// forwarding of a push into that same entry, so no beat ever waits on the ram port
// synchronous active-high reset; no clearing pass, queue entries are only read once written
// req_tready and csr_ready are low while reset is high
// req_tready otherwise drops only while a response is held and rsp_tready is low
module uart_status_and_data_register_model
   import uart_sdr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_in
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] read_data, [15:8] tx_byte
   output logic [1:0]  rsp_tuser,   // [0] tx_valid, [1] push_dropped
   output logic        rsp_tlast,   // tx_frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data     // tc_delay_ticks
);

`include "uart_status_and_data_register_model_defines.svh"

   logic       req_accept;
   rsp_type    core_rsp;
   logic [7:0] tc_delay_ff, tc_delay_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff;

   // csr writes are accepted whenever reset is low
   assign csr_ready   = !reset;
   assign tc_delay_in = (csr_valid && csr_ready) ? csr_data : tc_delay_ff;

   // take a new beat whenever the output register is free or draining
   assign req_tready   = !reset && (!rsp_valid_ff || rsp_tready);
   assign req_accept   = req_tvalid && req_tready;
   assign rsp_valid_in = req_accept || (rsp_valid_ff && !rsp_tready);

   uart_sdr_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .op       (op_type'(req_tuser)),
      .data_in  (req_tdata),
      .tc_delay (tc_delay_ff),
      .rsp      (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_delay_ff  <= TC_DELAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         tc_delay_ff  <= tc_delay_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded on every accepted beat
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= core_rsp;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.tx_byte, rsp_ff.read_data};
   assign rsp_tuser  = {rsp_ff.push_dropped, rsp_ff.tx_valid};
   assign rsp_tlast  = rsp_ff.tx_frame_end;

   `USDR_ASSERT_NEXT(a_accept_gives_response, req_accept, rsp_valid_ff)

endmodule
